@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character-to-sextet map of the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned NUM_RES   = 3;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned TOTAL_W   = 24;
  localparam logic [7:0]  PAD_CHAR  = 8'h3D;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } b64d_kind_e;

  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_OK  = 2'd1,
    PH_ERR = 2'd2
  } b64d_phase_e;

  typedef struct packed {
    logic             ok;
    logic [5:0]       val;
  } b64d_sx_t;

  // per-string decode state, minus the byte counter
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [1:0]       slot;
    logic             pad3;
    b64d_phase_e      phase;
  } b64d_grp_t;

  typedef struct packed {
    b64d_kind_e         kind;
    logic [7:0]         data;
    logic [TOTAL_W-1:0] total;
  } b64d_res_t;

  typedef b64d_res_t [NUM_RES-1:0] b64d_res_vec_t;

  function automatic b64d_sx_t sextet_of(input logic [7:0] ch);
    b64d_sx_t r;
    r.ok  = 1'b1;
    r.val = '0;
    case (ch) inside
      [8'h41:8'h5A]: r.val = 6'(ch - 8'h41);
      [8'h61:8'h7A]: r.val = 6'(ch - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.val = 6'(ch - 8'h30 + 8'd52);
      8'h2B:         r.val = 6'd62;
      8'h2F:         r.val = 6'd63;
      default:       r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/b64d_decode.sv @@
// ----------------------------------------------------------------------------
// b64d_decode
// Next-state and result logic for one text item: sextet gathering, padding
// rules, group split into bytes, saturating byte count and end-of-text status.
// ----------------------------------------------------------------------------
module b64d_decode #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                      cmd_i,
  input  logic [7:0]                char_i,
  input  b64d_pkg::b64d_grp_t       grp_i,
  input  logic [COUNT_BITS-1:0]     cnt_i,
  output b64d_pkg::b64d_grp_t       grp_o,
  output logic [COUNT_BITS-1:0]     cnt_o,
  output b64d_pkg::b64d_res_vec_t   res_o,
  output logic [1:0]                nres_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS:0]   wide1, wide2, wide3;
  logic [COUNT_BITS-1:0] sat1, sat2, sat3;
  b64d_pkg::b64d_sx_t    sx;
  logic                  is_pad;
  logic [23:0]           word;
  logic [1:0]            nb;
  b64d_pkg::b64d_kind_e  end_kind;

  assign wide1 = {1'b0, cnt_i} + (COUNT_BITS+1)'(1);
  assign wide2 = {1'b0, cnt_i} + (COUNT_BITS+1)'(2);
  assign wide3 = {1'b0, cnt_i} + (COUNT_BITS+1)'(3);
  assign sat1  = wide1[COUNT_BITS] ? CNT_MAX : wide1[COUNT_BITS-1:0];
  assign sat2  = wide2[COUNT_BITS] ? CNT_MAX : wide2[COUNT_BITS-1:0];
  assign sat3  = wide3[COUNT_BITS] ? CNT_MAX : wide3[COUNT_BITS-1:0];

  always_comb begin
    case (grp_i.phase)
      b64d_pkg::PH_ERR: end_kind = b64d_pkg::KIND_ERR;
      b64d_pkg::PH_RUN: begin
        end_kind = (grp_i.slot != 2'd0) ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
      end
      default: end_kind = b64d_pkg::KIND_OK;
    endcase
  end

  always_comb begin
    sx     = b64d_pkg::sextet_of(char_i);
    is_pad = (char_i == b64d_pkg::PAD_CHAR);
    grp_o  = grp_i;
    cnt_o  = cnt_i;
    res_o  = '0;
    nres_o = 2'd0;
    word   = '0;
    nb     = 2'd0;
    if (cmd_i) begin
      res_o[0].kind  = end_kind;
      res_o[0].total = b64d_pkg::TOTAL_W'(cnt_i);
      nres_o         = 2'd1;
      grp_o          = '0;
      grp_o.phase    = b64d_pkg::PH_RUN;
      cnt_o          = '0;
    end else if (grp_i.phase == b64d_pkg::PH_RUN) begin
      case (grp_i.slot)
        2'd0: begin
          if (!sx.ok) begin
            grp_o.phase = b64d_pkg::PH_OK;
          end else begin
            grp_o.acc  = {12'd0, sx.val};
            grp_o.slot = 2'd1;
          end
        end
        2'd1: begin
          if (!sx.ok) begin
            grp_o.phase = b64d_pkg::PH_ERR;
          end else begin
            grp_o.acc  = {grp_i.acc[11:0], sx.val};
            grp_o.slot = 2'd2;
          end
        end
        2'd2: begin
          if (is_pad) begin
            grp_o.pad3 = 1'b1;
            grp_o.acc  = {grp_i.acc[11:0], 6'd0};
            grp_o.slot = 2'd3;
          end else if (!sx.ok) begin
            grp_o.phase = b64d_pkg::PH_ERR;
          end else begin
            grp_o.acc  = {grp_i.acc[11:0], sx.val};
            grp_o.slot = 2'd3;
          end
        end
        default: begin
          if (is_pad) begin
            nb          = grp_i.pad3 ? 2'd1 : 2'd2;
            word        = {grp_i.acc, 6'd0};
            grp_o.phase = b64d_pkg::PH_OK;
          end else if (grp_i.pad3 || !sx.ok) begin
            grp_o.phase = b64d_pkg::PH_ERR;
          end else begin
            nb   = 2'd3;
            word = {grp_i.acc, sx.val};
          end
          if (nb != 2'd0) begin
            grp_o.acc  = '0;
            grp_o.slot = 2'd0;
            grp_o.pad3 = 1'b0;
          end
        end
      endcase
    end

    if (nb != 2'd0) begin
      nres_o         = nb;
      res_o[0].kind  = b64d_pkg::KIND_DATA;
      res_o[0].data  = word[23:16];
      res_o[0].total = b64d_pkg::TOTAL_W'(sat1);
      res_o[1].kind  = b64d_pkg::KIND_DATA;
      res_o[1].data  = word[15:8];
      res_o[1].total = b64d_pkg::TOTAL_W'(sat2);
      res_o[2].kind  = b64d_pkg::KIND_DATA;
      res_o[2].data  = word[7:0];
      res_o[2].total = b64d_pkg::TOTAL_W'(sat3);
      case (nb)
        2'd1:    cnt_o = sat1;
        2'd2:    cnt_o = sat2;
        default: cnt_o = sat3;
      endcase
    end
  end

endmodule

@@ rtl/b64d_obuf.sv @@
// ----------------------------------------------------------------------------
// b64d_obuf
// Result register for up to three results of one item, shifted out one
// transfer per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module b64d_obuf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  b64d_pkg::b64d_res_vec_t res_i,
  input  logic [1:0]              nres_i,
  input  logic                    ready_i,
  output logic                    can_load_o,
  output logic                    valid_o,
  output logic                    last_o,
  output b64d_pkg::b64d_res_t     head_o
);

  b64d_pkg::b64d_res_vec_t ent_q, ent_d;
  logic [1:0]              cnt_q, cnt_d;
  logic                    take;

  assign valid_o    = (cnt_q != 2'd0);
  assign last_o     = (cnt_q == 2'd1);
  assign head_o     = ent_q[0];
  assign take       = valid_o && ready_i;
  assign can_load_o = (cnt_q == 2'd0) || (take && last_o);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = res_i;
      cnt_d = nres_i;
    end else if (take) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

@@ rtl/base64_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming Base64 text decoder, one character per input transfer.
// ----------------------------------------------------------------------------
// Input channel: tuser = command (0 character, 1 end of text), tdata = the
// character code. Output channel: tuser = kind (data byte, end with success,
// end with error), tdata = data byte plus the running byte total, tlast on
// the final result that an input transfer causes.
// Each text character moves from the input register through the decode logic
// into the result register, updating the group state as it goes. A completed
// group loads up to three byte results at once; an end-of-text loads one
// status result and clears the string state.
// Each item is held in the input register, its results in the result register.
// Throughput: one input transfer per cycle while nothing stalls. Characters that
// produce no result pass even while earlier bytes drain; an item with results
// waits until the result register has delivered its last entry.
// Reset empties both registers and returns to the start of a string.
// A stalled receiver holds the head result; the input side fills its register
// and drops s_axis_tready once the held item has results to load.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [31:8] byte_total
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic                    in_valid_q, in_valid_d;
  logic                    in_cmd_q;
  logic [7:0]              in_char_q;
  b64d_pkg::b64d_grp_t     grp_q, grp_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  b64d_pkg::b64d_res_vec_t res;
  logic [1:0]              nres;
  logic                    can_load;
  logic                    move;
  logic                    load;
  logic                    s_xfer;
  b64d_pkg::b64d_res_t     head;

  b64d_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .cmd_i  (in_cmd_q),
    .char_i (in_char_q),
    .grp_i  (grp_q),
    .cnt_i  (cnt_q),
    .grp_o  (grp_d),
    .cnt_o  (cnt_d),
    .res_o  (res),
    .nres_o (nres)
  );

  assign move          = in_valid_q && ((nres == 2'd0) || can_load);
  assign load          = move && (nres != 2'd0);
  assign s_axis_tready = !in_valid_q || move;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      grp_q      <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (move) begin
        grp_q <= grp_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_cmd_q  <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
  end

  b64d_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_i      (res),
    .nres_i     (nres),
    .ready_i    (m_axis_tready),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .last_o     (m_axis_tlast),
    .head_o     (head)
  );

  assign m_axis_tdata = {head.total, head.data};
  assign m_axis_tuser = head.kind;

  a_end_result_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != b64d_pkg::KIND_DATA))
      |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'd0)))
    else $error("end result not last or carries data");

  a_group_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
      |=> (m_axis_tvalid && (m_axis_tuser == b64d_pkg::KIND_DATA)))
    else $error("byte group broken");

  a_stall_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && (nres != 2'd0) && m_axis_tvalid))
    else $error("input stalled without pending work");

endmodule

@@ tb/base64_stream_decoder_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_test
// Self-checking bench for the streaming Base64 decoder. Directed strings hit
// padding, error and early-end rules, then random well-formed and broken
// strings run with random gaps on both channels and one long output stall.
// A scoreboard predicts every byte and status result and compares in order.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core_test;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int ITEM_TARGET    = 165;

  class b64_decode_scoreboard;
    typedef struct {
      b64d_pkg::b64d_kind_e         kind;
      logic [7:0]                   data;
      logic [b64d_pkg::TOTAL_W-1:0] total;
      bit                           is_last;
    } decoded_t;

    decoded_t                     pending_results[$];
    int                           fail_count;
    logic [b64d_pkg::ACC_W-1:0]   acc;
    logic [1:0]                   slot;
    bit                           pad3;
    b64d_pkg::b64d_phase_e        phase;
    logic [b64d_pkg::TOTAL_W-1:0] byte_count;

    function new();
      fail_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      acc        = '0;
      slot       = '0;
      pad3       = 1'b0;
      phase      = b64d_pkg::PH_RUN;
      byte_count = '0;
    endfunction

    // 0..63 for alphabet characters, 64 otherwise
    function int sextet_index(logic [7:0] ch);
      for (int i = 0; i < 64; i++) begin
        if (B64_ALPHABET[i] == ch) return i;
      end
      return 64;
    endfunction

    function void push(b64d_pkg::b64d_kind_e kind, logic [7:0] data, bit is_last);
      decoded_t r;
      r.kind    = kind;
      r.data    = data;
      r.total   = byte_count;
      r.is_last = is_last;
      pending_results.push_back(r);
    endfunction

    function void predict_decode(bit cmd, logic [7:0] ch);
      int               sx;
      int               nbytes;
      logic [23:0]      word;
      logic [5:0]       bits6;
      if (cmd) begin
        if (phase == b64d_pkg::PH_ERR || (phase == b64d_pkg::PH_RUN && slot != 2'd0))
          push(b64d_pkg::KIND_ERR, 8'h00, 1'b1);
        else push(b64d_pkg::KIND_OK, 8'h00, 1'b1);
        clear_string();
        return;
      end
      if (phase != b64d_pkg::PH_RUN) return;
      sx    = sextet_index(ch);
      bits6 = sx[5:0];
      case (slot)
        2'd0: begin
          if (sx == 64) phase = b64d_pkg::PH_OK;
          else begin
            acc  = {12'd0, bits6};
            slot = 2'd1;
          end
        end
        2'd1: begin
          if (sx == 64) phase = b64d_pkg::PH_ERR;
          else begin
            acc  = {acc[11:0], bits6};
            slot = 2'd2;
          end
        end
        2'd2: begin
          if (ch == b64d_pkg::PAD_CHAR) begin
            pad3 = 1'b1;
            acc  = {acc[11:0], 6'd0};
            slot = 2'd3;
          end else if (sx == 64) phase = b64d_pkg::PH_ERR;
          else begin
            acc  = {acc[11:0], bits6};
            slot = 2'd3;
          end
        end
        default: begin
          if (ch == b64d_pkg::PAD_CHAR) begin
            nbytes = pad3 ? 1 : 2;
            word   = {acc, 6'd0};
            phase  = b64d_pkg::PH_OK;
          end else if (pad3 || sx == 64) begin
            phase = b64d_pkg::PH_ERR;
            return;
          end else begin
            nbytes = 3;
            word   = {acc, bits6};
          end
          for (int i = 0; i < nbytes; i++) begin
            if (byte_count != '1) byte_count++;
            push(b64d_pkg::KIND_DATA, word[23-8*i -: 8], i == nbytes - 1);
          end
          acc  = '0;
          slot = '0;
          pad3 = 1'b0;
        end
      endcase
    endfunction

    function void check_decoded(logic [1:0] kind, logic [7:0] data,
                                logic [b64d_pkg::TOTAL_W-1:0] total, logic is_last);
      decoded_t e;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result kind %0d data %02h total %0d last %0b",
                   $time, kind, data, total, is_last);
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind || data !== e.data || total !== e.total || is_last !== e.is_last) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch (exp/got) kind %0d/%0d data %02h/%02h ",
                    "total %0d/%0d last %0b/%0b"}, $time, e.kind, kind, e.data, data,
                   e.total, total, e.is_last, is_last);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               m_axis_tlast;

  b64_decode_scoreboard sb;
  int                   items_sent;
  int                   snd_quiet;
  int                   rcv_quiet;
  int                   stall_cycles;
  bit                   rcv_hold_req;

  base64_stream_decoder_core #(
    .COUNT_BITS(b64d_pkg::TOTAL_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random gap per transfer, with occasional runs of back-to-back transfers
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 30);
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] b64_char();
    return B64_ALPHABET[$urandom_range(0, 63)];
  endfunction

  function automatic logic [7:0] noisy_char();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick < 3) return b64_char();
    if (pick == 3) return b64d_pkg::PAD_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input bit cmd, input logic [7:0] ch);
    int gap;
    gap = draw_gap(snd_quiet);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(1'b0, s[i]);
    send_end();
  endtask

  task automatic send_wellformed();
    int n_groups;
    int pad;
    n_groups = $urandom_range(0, 4);
    repeat (4 * n_groups) send_item(1'b0, b64_char());
    pad = $urandom_range(0, 2);
    if (pad == 1) begin
      repeat (3) send_item(1'b0, b64_char());
      send_item(1'b0, b64d_pkg::PAD_CHAR);
    end else if (pad == 2) begin
      repeat (2) send_item(1'b0, b64_char());
      repeat (2) send_item(1'b0, b64d_pkg::PAD_CHAR);
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_item(1'b0, noisy_char());
    send_end();
  endtask

  task automatic send_broken();
    repeat ($urandom_range(0, 9)) send_item(1'b0, noisy_char());
    send_end();
  endtask

  // receiver
  initial begin
    int gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(rcv_quiet);
      if (rcv_hold_req) begin
        gap          = LONG_HOLD;
        rcv_hold_req = 1'b0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.predict_decode(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_decoded(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    sb            = new();
    items_sent    = 0;
    snd_quiet     = 0;
    rcv_quiet     = 0;
    stall_cycles  = 0;
    rcv_hold_req  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // full groups of ones and zeros, two-byte pad, ignored trailing text; one-byte pad
    send_text("////AAA=Z");
    send_text("QQ==");
    // pad in third place without pad in fourth
    send_text("QU=A");
    // pad in second place
    send_text("Q=");
    // text ends mid-group
    send_text("Q");
    // code zero at group start ends the decode, rest ignored
    send_item(1'b0, 8'h00);
    send_item(1'b0, "Q");
    send_end();
    // empty string
    send_end();

    rcv_hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) send_wellformed();
      else send_broken();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_obuf.sv
rtl/base64_stream_decoder_core.sv
tb/base64_stream_decoder_core_test.sv
